### sv/lawa_pkg.sv
// Package for the link-activity watchdog with baud-rate search.
// Holds field widths, action and register codes and reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lawa_pkg;

	localparam int LAWA_MAX_RATES = 16;

	localparam int ACTION_W     = 2;
	localparam int TOTAL_W      = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 8;
	localparam int CNT8_W       = 8;
	localparam int RATE_COUNT_W = 5;
	localparam int RATE_INDEX_W = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK     = 2'd0,
		ACT_UP_START = 2'd1,
		ACT_UP_DONE  = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AUTO_SPEED    = 3'd0,
		REG_PLAIN_LINK    = 3'd1,
		REG_TIMEOUT_SHORT = 3'd2,
		REG_TIMEOUT_LONG  = 3'd3,
		REG_REQUEST_SHORT = 3'd4,
		REG_REQUEST_LONG  = 3'd5,
		REG_GHOST_TICKS   = 3'd6,
		REG_RATE_COUNT    = 3'd7
	} cfg_reg_t;

	localparam logic [CNT8_W-1:0]       RST_TIMEOUT_SHORT = 8'd4;
	localparam logic [CNT8_W-1:0]       RST_TIMEOUT_LONG  = 8'd16;
	localparam logic [CNT8_W-1:0]       RST_REQUEST_SHORT = 8'd2;
	localparam logic [CNT8_W-1:0]       RST_REQUEST_LONG  = 8'd32;
	localparam logic [CNT8_W-1:0]       RST_GHOST_TICKS   = 8'd2;
	localparam logic [RATE_COUNT_W-1:0] RST_RATE_COUNT    = 5'd0;

endpackage
`default_nettype wire

### sv/lawa_if.sv
// Valid/ready channel interfaces for the watchdog: input items, results, register writes.
// Depends on lawa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lawa_item_if
	import lawa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic                link_open;
	logic [TOTAL_W-1:0]  frame_total;

	modport source (output valid, action, link_open, frame_total, input ready);
	modport sink (input valid, action, link_open, frame_total, output ready);
endinterface

interface lawa_result_if
	import lawa_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    receiving;
	logic                    receiving_changed;
	logic                    try_rate;
	logic [RATE_INDEX_W-1:0] rate_index;
	logic                    send_poll;
	logic                    upgrading;

	modport source (output valid, receiving, receiving_changed, try_rate, rate_index,
		send_poll, upgrading, input ready);
	modport sink (input valid, receiving, receiving_changed, try_rate, rate_index,
		send_poll, upgrading, output ready);
endinterface

interface lawa_cfg_if
	import lawa_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/link_activity_watchdog_autobaud_core.sv
// Top level of the link-activity watchdog with baud-rate search.
// Depends on lawa_pkg and the channel interfaces in lawa_if.sv.
//
// Usage: each transfer on the item channel is a check tick or a firmware-upgrade
// event, and it produces exactly one transfer on the result channel. Register
// writes arrive on the cfg channel, which is always ready, and are meant to be
// issued only while no item is in flight.
// An accepted item is held in an input register, and its result is written into
// the result register when that register is free; the result stays valid in the
// result register until the receiver takes it.
// One item is accepted every cycle while the receiver takes results: the state
// counters update in the same single pass that forms the result.
// When the receiver stalls, the result register holds its value and the input
// register keeps one more item; the item channel then drops ready until the
// result is taken.
// Reset clears both registers and loads the register defaults and the initial
// timeout and poll counts.
`timescale 1ns / 1ps
`default_nettype none
module link_activity_watchdog_autobaud_core
	import lawa_pkg::*;
#(
	parameter int MAX_RATES = LAWA_MAX_RATES
) (
	input  wire           clk,
	input  wire           arst_n,
	lawa_item_if.sink     item,
	lawa_result_if.source result,
	lawa_cfg_if.sink      cfg
);

	localparam int CLOG_CNT = $clog2(MAX_RATES + 1);
	localparam int CNT_W    = (CLOG_CNT > RATE_COUNT_W) ? CLOG_CNT : RATE_COUNT_W;
	localparam int CLOG_POS = $clog2(MAX_RATES);
	localparam int POS_W    = (CLOG_POS > 1) ? CLOG_POS : 1;
	localparam int IDX_W    = (POS_W > RATE_INDEX_W) ? POS_W : RATE_INDEX_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RATES);

	logic                    auto_speed_q;
	logic                    plain_link_q;
	logic [CNT8_W-1:0]       timeout_short_q;
	logic [CNT8_W-1:0]       timeout_long_q;
	logic [CNT8_W-1:0]       request_short_q;
	logic [CNT8_W-1:0]       request_long_q;
	logic [CNT8_W-1:0]       ghost_ticks_q;
	logic [RATE_COUNT_W-1:0] rate_count_q;

	logic [TOTAL_W-1:0] last_total_q;
	logic               receiving_q;
	logic [CNT8_W-1:0]  timeout_q;
	logic [CNT8_W-1:0]  ghost_q;
	logic [CNT8_W-1:0]  poll_q;
	logic [POS_W-1:0]   pos_q;
	logic               upgrade_q;

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic                link_open_s1;
	logic [TOTAL_W-1:0]  total_s1;

	logic                    out_valid_q;
	logic                    out_receiving_q;
	logic                    out_changed_q;
	logic                    out_try_q;
	logic [RATE_INDEX_W-1:0] out_index_q;
	logic                    out_poll_q;
	logic                    out_upgrading_q;

	logic out_free;
	logic advance;
	logic cfg_write;

	logic               tick;
	logic               new_frames;
	logic               ghost_nz;
	logic [CNT8_W-1:0]  timeout_dec;
	logic               rcv_a;
	logic [CNT8_W-1:0]  timeout_a;
	logic [CNT8_W-1:0]  ghost_a;
	logic [POS_W-1:0]   pos_a;
	logic [CNT_W-1:0]   count;
	logic               search;
	logic [POS_W-1:0]   pos_b;
	logic [CNT_W-1:0]   pos_inc;
	logic [IDX_W-1:0]   idx_ext;
	logic               poll_fire;
	logic [CNT8_W-1:0]  poll_base;

	logic               rcv_n;
	logic               changed_n;
	logic               try_n;
	logic [RATE_INDEX_W-1:0] index_n;
	logic               poll_n;
	logic               upgrade_n;
	logic [CNT8_W-1:0]  timeout_n;
	logic [CNT8_W-1:0]  ghost_n;
	logic [CNT8_W-1:0]  poll_left_n;
	logic [POS_W-1:0]   pos_n;
	logic [TOTAL_W-1:0] last_total_n;

	assign out_free     = !out_valid_q || result.ready;
	assign advance      = valid_s1 && out_free;
	assign item.ready   = !valid_s1 || out_free;
	assign cfg.ready    = 1'b1;
	assign cfg_write    = cfg.valid;

	assign tick        = (action_s1 == ACT_TICK) && link_open_s1;
	assign new_frames  = total_s1 != last_total_q;
	assign ghost_nz    = ghost_q != '0;
	assign timeout_dec = (timeout_q != '0) ? timeout_q - 8'd1 : timeout_q;
	assign count = (CNT_W'(rate_count_q) > MAX_CNT) ? MAX_CNT : CNT_W'(rate_count_q);

	always_comb begin
		if (new_frames) begin
			rcv_a     = ghost_nz ? receiving_q : 1'b1;
			timeout_a = ghost_nz ? timeout_q : timeout_long_q;
			ghost_a   = ghost_nz ? ghost_q - 8'd1 : ghost_q;
			pos_a     = ghost_nz ? pos_q : '0;
		end else begin
			rcv_a     = (timeout_dec == '0) ? 1'b0 : receiving_q;
			timeout_a = timeout_dec;
			ghost_a   = ghost_q;
			pos_a     = pos_q;
		end
	end

	assign search = (auto_speed_q || upgrade_q || ghost_a != '0) && !rcv_a &&
		timeout_a == '0 && count != '0;
	assign pos_b     = (CNT_W'(pos_a) >= count) ? '0 : pos_a;
	assign pos_inc   = CNT_W'(pos_b) + CNT_W'(1);
	assign idx_ext   = IDX_W'(pos_b);
	assign poll_fire = !rcv_a || poll_q == '0;
	assign poll_base = (poll_q == '0) ?
		((!upgrade_q && rcv_a) ? request_long_q : request_short_q) : poll_q;

	always_comb begin
		rcv_n        = receiving_q;
		changed_n    = 1'b0;
		try_n        = 1'b0;
		index_n      = '0;
		poll_n       = 1'b0;
		upgrade_n    = upgrade_q;
		timeout_n    = timeout_q;
		ghost_n      = ghost_q;
		poll_left_n  = poll_q;
		pos_n        = pos_q;
		last_total_n = last_total_q;
		if (action_s1 == ACT_UP_START) begin
			upgrade_n   = 1'b1;
			timeout_n   = timeout_short_q;
			poll_left_n = request_short_q;
			pos_n       = '0;
		end else if (action_s1 == ACT_UP_DONE) begin
			upgrade_n   = 1'b0;
			timeout_n   = timeout_short_q;
			ghost_n     = ghost_ticks_q;
			poll_left_n = request_long_q;
			pos_n       = '0;
		end else if (tick) begin
			rcv_n        = rcv_a;
			changed_n    = rcv_a != receiving_q;
			ghost_n      = ghost_a;
			last_total_n = total_s1;
			poll_n       = poll_fire && plain_link_q;
			poll_left_n  = (poll_fire ? poll_base : poll_q) - 8'd1;
			if (search) begin
				timeout_n = timeout_short_q;
				try_n     = 1'b1;
				index_n   = idx_ext[RATE_INDEX_W-1:0];
				pos_n     = (pos_inc == count) ? '0 : pos_inc[POS_W-1:0];
			end else begin
				timeout_n = timeout_a;
				pos_n     = pos_a;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_speed_q    <= 1'b0;
			plain_link_q    <= 1'b1;
			timeout_short_q <= RST_TIMEOUT_SHORT;
			timeout_long_q  <= RST_TIMEOUT_LONG;
			request_short_q <= RST_REQUEST_SHORT;
			request_long_q  <= RST_REQUEST_LONG;
			ghost_ticks_q   <= RST_GHOST_TICKS;
			rate_count_q    <= RST_RATE_COUNT;
		end else if (cfg_write) begin
			case (cfg.index)
				REG_AUTO_SPEED:    auto_speed_q    <= cfg.data[0];
				REG_PLAIN_LINK:    plain_link_q    <= cfg.data[0];
				REG_TIMEOUT_SHORT: timeout_short_q <= cfg.data;
				REG_TIMEOUT_LONG:  timeout_long_q  <= cfg.data;
				REG_REQUEST_SHORT: request_short_q <= cfg.data;
				REG_REQUEST_LONG:  request_long_q  <= cfg.data;
				REG_GHOST_TICKS:   ghost_ticks_q   <= cfg.data;
				REG_RATE_COUNT:    rate_count_q    <= cfg.data[RATE_COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
			receiving_q  <= 1'b0;
			timeout_q    <= RST_TIMEOUT_SHORT;
			ghost_q      <= '0;
			poll_q       <= RST_REQUEST_LONG;
			pos_q        <= '0;
			upgrade_q    <= 1'b0;
		end else begin
			if (advance) begin
				last_total_q <= last_total_n;
				receiving_q  <= rcv_n;
				timeout_q    <= timeout_n;
				ghost_q      <= ghost_n;
				poll_q       <= poll_left_n;
				upgrade_q    <= upgrade_n;
			end
			if (cfg_write && cfg.index == REG_AUTO_SPEED) begin
				pos_q <= '0;
			end else if (advance) begin
				pos_q <= pos_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1    <= item.action;
			link_open_s1 <= item.link_open;
			total_s1     <= item.frame_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_receiving_q <= rcv_n;
			out_changed_q   <= changed_n;
			out_try_q       <= try_n;
			out_index_q     <= index_n;
			out_poll_q      <= poll_n;
			out_upgrading_q <= upgrade_n;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.receiving         = out_receiving_q;
	assign result.receiving_changed = out_changed_q;
	assign result.try_rate          = out_try_q;
	assign result.rate_index        = out_index_q;
	assign result.send_poll         = out_poll_q;
	assign result.upgrading         = out_upgrading_q;

endmodule
`default_nettype wire
